// ===== rtl/core/heightmap_bilinear_height_query_core_assert.svh =====
// assertion macros shared by the core
`ifndef HEIGHTMAP_BILINEAR_HEIGHT_QUERY_CORE_ASSERT_SVH
`define HEIGHTMAP_BILINEAR_HEIGHT_QUERY_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HBQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbq assertion failed");

// next-cycle implication, disabled during reset
`define HBQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbq assertion failed");

`endif

// ===== rtl/core/hbq_pkg.sv =====
package hbq_pkg;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_Z  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFF_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFF_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LENGTH  = 3'd5;

    localparam int CFG_DATA_W   = 16;
    localparam int GRID_SIZE_W  = 9;
    localparam int CELL_W       = 3;
    localparam int FRAC_W       = 8;
    localparam int WORLD_W      = 24;
    localparam int PROD_W       = 41;
    localparam int GPOS_W       = 34;
    localparam int CORNER_W     = 6;
    localparam int WEIGHT_W     = 10;
    localparam int EDGE_W       = 16;
    localparam int MIX_W        = 26;
    localparam int MIX_FRAC_W   = 16;

    // corner slots, in read order
    localparam logic [1:0] CORNER_BL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd1;
    localparam logic [1:0] CORNER_TL = 2'd2;
    localparam logic [1:0] CORNER_TR = 2'd3;
    localparam logic [2:0] READ_LAST = 3'd4;

    typedef struct packed {
        logic                      command;
        logic [7:0]                sample_column;
        logic [7:0]                sample_row;
        logic [7:0]                raw_height;
        logic signed [WORLD_W-1:0] world_x;
        logic signed [WORLD_W-1:0] world_z;
        logic                      reverse_quad;
    } hbq_req_t;

    typedef struct packed {
        logic [CELL_W-1:0] height;
        logic              out_of_range;
    } hbq_rsp_t;

    typedef logic [3:0][CELL_W-1:0] hbq_corners_t;

    typedef struct packed {
        logic corr_en;
        logic edge_en;
        logic mix_en;
    } hbq_interp_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_POS,
        ST_CHK,
        ST_READ,
        ST_CORR,
        ST_EDGE,
        ST_MIX,
        ST_DONE
    } hbq_state_t;

endpackage

// ===== rtl/core/heightmap_bilinear_height_query_core.sv =====
// A query steps through MUL, POS, CHK, READ, CORR, EDGE, MIX and DONE (CHK to DONE when out of range);
// a new request is taken only in IDLE, once the previous result is loaded into the output register,
// and the four corner reads go one by one through the single read port of the grid memory.
// Reset: control state and configuration registers take their reset values
// asynchronously on rst_n low; the grid memory is not cleared and holds no value until written.
`include "heightmap_bilinear_height_query_core_assert.svh"

module heightmap_bilinear_height_query_core
    import hbq_pkg::*;
#(
    parameter int MAX_GRID_WIDTH  = 256,
    parameter int MAX_GRID_LENGTH = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  hbq_req_t              req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output hbq_rsp_t              rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_GRID_WIDTH * MAX_GRID_LENGTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int WSW   = ($clog2(MAX_GRID_WIDTH + 1) > GRID_SIZE_W)
                           ? $clog2(MAX_GRID_WIDTH + 1) : GRID_SIZE_W;
    localparam int LSW   = ($clog2(MAX_GRID_LENGTH + 1) > GRID_SIZE_W)
                           ? $clog2(MAX_GRID_LENGTH + 1) : GRID_SIZE_W;

    // configuration registers
    logic [CFG_DATA_W-1:0]  inv_scale_x_reg, inv_scale_z_reg;
    logic [CFG_DATA_W-1:0]  center_off_x_reg, center_off_z_reg;
    logic [GRID_SIZE_W-1:0] grid_width_reg, grid_length_reg;

    // control
    hbq_state_t             state_reg, state_next;
    logic [2:0]             rd_cnt_reg;
    logic                   rsp_valid_reg;
    hbq_rsp_t               rsp_reg, rsp_next;

    // datapath
    hbq_req_t               req_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_z_reg;
    logic signed [GPOS_W-1:0] gx_reg, gz_reg;
    logic [AW-1:0]          base_reg;
    logic [FRAC_W-1:0]      fx_reg, fz_reg;
    logic                   oor_reg, oor_next;
    hbq_corners_t           corners_reg;

    logic [WSW-1:0]         eff_w;
    logic [LSW-1:0]         eff_l;
    logic                   load_ok;
    logic [AW-1:0]          wr_addr, rd_addr, base_next;
    logic [CELL_W-1:0]      rd_data_reg;
    logic                   mem_we, rd_en, capture, rsp_load, req_xfer, out_free;
    hbq_interp_ctrl_t       interp_ctrl;
    logic signed [MIX_W-1:0] mix;

    logic [CELL_W-1:0]      grid_mem [DEPTH];

    assign cfg_ready = 1'b1;
    assign req_xfer  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale_x_reg  <= 16'd256;
            inv_scale_z_reg  <= 16'd256;
            center_off_x_reg <= '0;
            center_off_z_reg <= '0;
            grid_width_reg   <= 9'd256;
            grid_length_reg  <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INV_SCALE_X:  inv_scale_x_reg  <= cfg_data;
                CFG_INV_SCALE_Z:  inv_scale_z_reg  <= cfg_data;
                CFG_CENTER_OFF_X: center_off_x_reg <= cfg_data;
                CFG_CENTER_OFF_Z: center_off_z_reg <= cfg_data;
                CFG_GRID_WIDTH:   grid_width_reg   <= cfg_data[GRID_SIZE_W-1:0];
                CFG_GRID_LENGTH:  grid_length_reg  <= cfg_data[GRID_SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // grid size in use
    assign eff_w = (WSW'(grid_width_reg) < WSW'(MAX_GRID_WIDTH))
                   ? WSW'(grid_width_reg) : WSW'(MAX_GRID_WIDTH);
    assign eff_l = (LSW'(grid_length_reg) < LSW'(MAX_GRID_LENGTH))
                   ? LSW'(grid_length_reg) : LSW'(MAX_GRID_LENGTH);

    // load address with the row flipped
    assign load_ok = (32'(req_reg.sample_column) < 32'(eff_w))
                     && (32'(req_reg.sample_row) < 32'(eff_l));
    assign wr_addr = AW'(eff_l - LSW'(1) - LSW'(req_reg.sample_row)) * AW'(MAX_GRID_WIDTH)
                     + AW'(req_reg.sample_column);

    // cell range check and base address of the bottom-left corner
    assign oor_next = gx_reg[GPOS_W-1] || gz_reg[GPOS_W-1]
                      || (32'(gx_reg[GPOS_W-2:FRAC_W]) + 32'd1 >= 32'(eff_w))
                      || (32'(gz_reg[GPOS_W-2:FRAC_W]) + 32'd1 >= 32'(eff_l));
    assign base_next = AW'(gz_reg[GPOS_W-2:FRAC_W]) * AW'(MAX_GRID_WIDTH)
                       + AW'(gx_reg[GPOS_W-2:FRAC_W]);

    // corner read address
    always_comb
    begin
        case (rd_cnt_reg[1:0])
            CORNER_BL: rd_addr = base_reg;
            CORNER_BR: rd_addr = base_reg + AW'(1);
            CORNER_TL: rd_addr = base_reg + AW'(MAX_GRID_WIDTH);
            default:   rd_addr = base_reg + AW'(MAX_GRID_WIDTH) + AW'(1);
        endcase
    end

    // grid memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[wr_addr] <= req_reg.raw_height[7:5];
        if (rd_en)
            rd_data_reg <= grid_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_xfer)
                    state_next = (req.command == CMD_QUERY) ? ST_MUL : ST_LOAD;
            ST_LOAD: state_next = ST_IDLE;
            ST_MUL:  state_next = ST_POS;
            ST_POS:  state_next = ST_CHK;
            ST_CHK:  state_next = oor_next ? ST_DONE : ST_READ;
            ST_READ:
                if (rd_cnt_reg == READ_LAST)
                    state_next = ST_CORR;
            ST_CORR: state_next = ST_EDGE;
            ST_EDGE: state_next = ST_MIX;
            ST_MIX:  state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req_stall           = (state_reg != ST_IDLE);
        mem_we              = (state_reg == ST_LOAD) && load_ok;
        rd_en               = (state_reg == ST_READ) && !rd_cnt_reg[2];
        capture             = (state_reg == ST_READ) && (rd_cnt_reg != 3'd0);
        interp_ctrl.corr_en = (state_reg == ST_CORR);
        interp_ctrl.edge_en = (state_reg == ST_EDGE);
        interp_ctrl.mix_en  = (state_reg == ST_MIX);
        rsp_load            = (state_reg == ST_DONE) && out_free;
    end

    // result: zero when out of range, else truncated and clamped
    always_comb
    begin
        rsp_next.out_of_range = oor_reg;
        if (oor_reg || mix[MIX_W-1])
            rsp_next.height = '0;
        else if (|mix[MIX_W-2:MIX_FRAC_W+CELL_W])
            rsp_next.height = '1;
        else
            rsp_next.height = mix[MIX_FRAC_W+CELL_W-1:MIX_FRAC_W];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CHK)
                rd_cnt_reg <= '0;
            else if (state_reg == ST_READ)
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
            req_reg <= req;
        if (state_reg == ST_MUL)
        begin
            prod_x_reg <= PROD_W'(req_reg.world_x) * PROD_W'($signed({1'b0, inv_scale_x_reg}));
            prod_z_reg <= PROD_W'(req_reg.world_z) * PROD_W'($signed({1'b0, inv_scale_z_reg}));
        end
        if (state_reg == ST_POS)
        begin
            gx_reg <= GPOS_W'(prod_x_reg >>> FRAC_W)
                      + GPOS_W'($signed({1'b0, center_off_x_reg}));
            gz_reg <= GPOS_W'(prod_z_reg >>> FRAC_W)
                      + GPOS_W'($signed({1'b0, center_off_z_reg}));
        end
        if (state_reg == ST_CHK)
        begin
            oor_reg  <= oor_next;
            base_reg <= base_next;
            fx_reg   <= gx_reg[FRAC_W-1:0];
            fz_reg   <= gz_reg[FRAC_W-1:0];
        end
        if (capture)
            corners_reg[rd_cnt_reg[1:0] - 2'd1] <= rd_data_reg;
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    hbq_interp u_interp (
        .clk          (clk),
        .ctrl         (interp_ctrl),
        .corners      (corners_reg),
        .fx           (fx_reg),
        .fz           (fz_reg),
        .reverse_quad (req_reg.reverse_quad),
        .mix          (mix)
    );

    // checks
    `HBQ_ASSERT_NXT(a_query_enters_mul, clk, rst_n,
        req_xfer && req.command == CMD_QUERY, state_reg == ST_MUL)
    `HBQ_ASSERT_IMP(a_oor_height_zero, clk, rst_n,
        rsp_valid && rsp.out_of_range, rsp.height == '0)
    `HBQ_ASSERT_IMP(a_read_count_bound, clk, rst_n,
        state_reg == ST_READ, rd_cnt_reg <= READ_LAST)
    `HBQ_ASSERT_NXT(a_done_waits_on_stall, clk, rst_n,
        state_reg == ST_DONE && rsp_valid && rsp_stall, state_reg == ST_DONE)

endmodule

// ===== rtl/core/hbq_interp.sv =====
module hbq_interp
    import hbq_pkg::*;
(
    input  logic                    clk,
    input  hbq_interp_ctrl_t        ctrl,
    input  hbq_corners_t            corners,
    input  logic [FRAC_W-1:0]       fx,
    input  logic [FRAC_W-1:0]       fz,
    input  logic                    reverse_quad,
    output logic signed [MIX_W-1:0] mix
);

    logic signed [CORNER_W-1:0] bl_reg, br_reg, tl_reg, tr_reg;
    logic signed [CORNER_W-1:0] bl_next, br_next, tl_next, tr_next;
    logic signed [EDGE_W-1:0]   top_reg, bot_reg, top_next, bot_next;
    logic signed [MIX_W-1:0]    mix_reg, mix_next;
    logic signed [WEIGHT_W-1:0] fx_w, fz_w, fx_inv, fz_inv;

    // fraction weights
    assign fx_w   = $signed({2'b00, fx});
    assign fz_w   = $signed({2'b00, fz});
    assign fx_inv = 10'sd256 - fx_w;
    assign fz_inv = 10'sd256 - fz_w;

    // planar correction of the corner opposite the chosen triangle
    always_comb
    begin
        bl_next = $signed({3'b000, corners[CORNER_BL]});
        br_next = $signed({3'b000, corners[CORNER_BR]});
        tl_next = $signed({3'b000, corners[CORNER_TL]});
        tr_next = $signed({3'b000, corners[CORNER_TR]});
        if (reverse_quad)
        begin
            if (fz >= fx)
                br_next = bl_next + tr_next - tl_next;
            else
                tl_next = tr_next + bl_next - br_next;
        end
        else
        begin
            if ({1'b0, fx} + {1'b0, fz} < 9'd256)
                tr_next = tl_next + br_next - bl_next;
            else
                bl_next = tl_next + br_next - tr_next;
        end
    end

    // interpolation along x, then along z
    assign top_next = EDGE_W'(tl_reg) * EDGE_W'(fx_inv) + EDGE_W'(tr_reg) * EDGE_W'(fx_w);
    assign bot_next = EDGE_W'(bl_reg) * EDGE_W'(fx_inv) + EDGE_W'(br_reg) * EDGE_W'(fx_w);
    assign mix_next = MIX_W'(bot_reg) * MIX_W'(fz_inv) + MIX_W'(top_reg) * MIX_W'(fz_w);

    // stage registers
    always_ff @(posedge clk)
    begin
        if (ctrl.corr_en)
        begin
            bl_reg <= bl_next;
            br_reg <= br_next;
            tl_reg <= tl_next;
            tr_reg <= tr_next;
        end
        if (ctrl.edge_en)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
        end
        if (ctrl.mix_en)
            mix_reg <= mix_next;
    end

    assign mix = mix_reg;

endmodule
